[src/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants of the bitmap frame allocator: field widths,
// request and result codes, controller states and the command/status bundles
// between controller and datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

   localparam int PAGE_FRAME_W = 12;
   localparam int CFG_W        = 13;
   localparam int STATUS_W     = 3;
   localparam int GROUP_SIZE   = 8;

   localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_ALLOCATED = 3'd0,
      ST_HAD_FRAME = 3'd1,
      ST_NO_FRAME  = 3'd2,
      ST_FREED     = 3'd3,
      ST_NOTHING   = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_PICK,
      S_FIND,
      S_FREE_RD,
      S_FREE_WR,
      S_REPLY
   } state_type;

   typedef struct packed {
      logic load;
      logic scan;
      logic pick;
      logic find;
      logic free_rd;
      logic free_wr;
      logic reply;
   } ctrl_cmd_type;

   typedef struct packed {
      logic alloc_req;
      logic pf_zero;
      logic pf_in_range;
   } ctrl_stat_type;

endpackage

[src/bfa_ctrl.sv]
// ----------------------------------------------------------------------------
// bfa_ctrl
// Sequencer of the frame allocator: steps one request through search,
// read-modify-write of one bitmap word and the result strobe.
// ----------------------------------------------------------------------------
module bfa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  bfa_pkg::ctrl_stat_type stat,
   output bfa_pkg::ctrl_cmd_type  cmd
);

   bfa_pkg::state_type state_ff;
   bfa_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bfa_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bfa_pkg::S_IDLE: begin
            if (start) begin
               if (stat.alloc_req && stat.pf_zero) begin
                  state_in = bfa_pkg::S_SCAN;
               end else if (!stat.alloc_req && !stat.pf_zero && stat.pf_in_range) begin
                  state_in = bfa_pkg::S_FREE_RD;
               end else begin
                  state_in = bfa_pkg::S_REPLY;
               end
            end
         end
         bfa_pkg::S_SCAN:    state_in = bfa_pkg::S_PICK;
         bfa_pkg::S_PICK:    state_in = bfa_pkg::S_FIND;
         bfa_pkg::S_FIND:    state_in = bfa_pkg::S_IDLE;
         bfa_pkg::S_FREE_RD: state_in = bfa_pkg::S_FREE_WR;
         bfa_pkg::S_FREE_WR: state_in = bfa_pkg::S_IDLE;
         bfa_pkg::S_REPLY:   state_in = bfa_pkg::S_IDLE;
         default:            state_in = bfa_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      case (state_ff)
         bfa_pkg::S_IDLE: begin
            busy     = 1'b0;
            cmd.load = start;
         end
         bfa_pkg::S_SCAN:    cmd.scan    = 1'b1;
         bfa_pkg::S_PICK:    cmd.pick    = 1'b1;
         bfa_pkg::S_FIND:    cmd.find    = 1'b1;
         bfa_pkg::S_FREE_RD: cmd.free_rd = 1'b1;
         bfa_pkg::S_FREE_WR: cmd.free_wr = 1'b1;
         bfa_pkg::S_REPLY:   cmd.reply   = 1'b1;
         default:            busy        = 1'b1;
      endcase
   end

endmodule

[src/bfa_datapath.sv]
// ----------------------------------------------------------------------------
// bfa_datapath
// Bitmap word memory with per-word valid and full flags, the two-level
// first-free search, the bit encoder and the registered result.
// ----------------------------------------------------------------------------
module bfa_datapath #(
   parameter int MAX_FRAMES = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  bfa_pkg::ctrl_cmd_type               cmd,
   output bfa_pkg::ctrl_stat_type              stat,
   input  logic                                req_action,
   input  logic [bfa_pkg::PAGE_FRAME_W-1:0]    req_page_frame,
   input  logic                                req_kernel_page,
   input  logic                                req_writable,
   input  logic                                csr_wr_en,
   input  logic [bfa_pkg::CFG_W-1:0]           csr_wr_data,
   output logic                                rsp_valid,
   output logic [bfa_pkg::PAGE_FRAME_W-1:0]    rsp_new_frame,
   output logic                                rsp_present_bit,
   output logic                                rsp_rw_bit,
   output logic                                rsp_user_bit,
   output logic [bfa_pkg::STATUS_W-1:0]        rsp_status
);

   localparam int NUM_WORDS  = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
   localparam int WADDR_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int BIT_W      = $clog2(WORD_BITS);
   localparam int MAXF_W     = $clog2(MAX_FRAMES + 1);
   localparam int LIM_W      = (MAXF_W > bfa_pkg::CFG_W) ? MAXF_W : bfa_pkg::CFG_W;
   localparam int GSIZE      = bfa_pkg::GROUP_SIZE;
   localparam int NUM_GROUPS = (NUM_WORDS + GSIZE - 1) / GSIZE;
   localparam int GRP_W      = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
   localparam int LANE_W     = $clog2(GSIZE);
   localparam int PAD_W      = NUM_GROUPS * GSIZE;
   localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_FRAMES);

   // configuration and latched request
   logic [bfa_pkg::CFG_W-1:0]        cfg_ff;
   logic                             action_ff;
   logic [bfa_pkg::PAGE_FRAME_W-1:0] pf_ff;
   logic                             kern_ff;
   logic                             wr_ff;

   // bitmap store
   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [NUM_WORDS-1:0] word_valid_ff;
   logic [NUM_WORDS-1:0] word_full_ff;
   logic [WORD_BITS-1:0] mem_rd_ff;
   logic                 rd_valid_ff;
   logic [WADDR_W-1:0]   addr_ff;
   logic [WADDR_W-1:0]   rd_addr;

   // search
   logic [LIM_W-1:0]      cfg_ext;
   logic [LIM_W-1:0]      limit;
   logic [PAD_W-1:0]      avail;
   logic [NUM_GROUPS-1:0] grp_any_in;
   logic [NUM_GROUPS-1:0] grp_any_ff;
   logic                  grp_found;
   logic [GRP_W-1:0]      grp_sel;
   logic [GSIZE-1:0]      lane_avail;
   logic [LANE_W-1:0]     lane_sel;
   logic [WADDR_W-1:0]    pick_word;
   logic                  found_word_ff;

   // bit level
   logic [WORD_BITS-1:0] eff_word;
   logic                 zero_found;
   logic [BIT_W-1:0]     bit_sel;
   logic [LIM_W-1:0]     frame_idx;
   logic                 alloc_ok;
   logic [WORD_BITS-1:0] word_set;
   logic [LIM_W-1:0]     pf_ext;
   logic [WADDR_W-1:0]   free_word;
   logic [BIT_W-1:0]     free_bit;
   logic [WORD_BITS-1:0] word_clr;

   // result
   logic                             rsp_valid_ff;
   logic [bfa_pkg::PAGE_FRAME_W-1:0] rsp_frame_ff;
   logic                             rsp_present_ff;
   logic                             rsp_rw_ff;
   logic                             rsp_user_ff;
   bfa_pkg::status_type              rsp_status_ff;
   logic [bfa_pkg::PAGE_FRAME_W-1:0] rsp_frame_in;
   logic                             rsp_present_in;
   logic                             rsp_rw_in;
   logic                             rsp_user_in;
   bfa_pkg::status_type              rsp_status_in;

   assign stat.alloc_req   = (req_action == bfa_pkg::ACT_ALLOC);
   assign stat.pf_zero     = (req_page_frame == '0);
   assign stat.pf_in_range = (LIM_W'(req_page_frame) < MAX_LIM);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= bfa_pkg::CFG_RESET;
      end else if (csr_wr_en) begin
         cfg_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= req_action;
         pf_ff     <= req_page_frame;
         kern_ff   <= req_kernel_page;
         wr_ff     <= req_writable;
      end
   end

   // search limit is the managed frame count, saturated at MAX_FRAMES
   assign cfg_ext = LIM_W'(cfg_ff);
   assign limit   = (cfg_ext > MAX_LIM) ? MAX_LIM : cfg_ext;

   always_comb begin
      avail = '0;
      for (int w = 0; w < NUM_WORDS; w++) begin
         avail[w] = !word_full_ff[w] && (LIM_W'(w * WORD_BITS) < limit);
      end
   end

   always_comb begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
         grp_any_in[g] = |avail[g*GSIZE +: GSIZE];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         grp_any_ff <= grp_any_in;
      end
   end

   // lowest group with a free word, then lowest word inside it
   always_comb begin
      grp_found = 1'b0;
      grp_sel   = '0;
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if (grp_any_ff[g]) begin
            grp_found = 1'b1;
            grp_sel   = GRP_W'(g);
         end
      end
   end

   assign lane_avail = avail[grp_sel*GSIZE +: GSIZE];

   always_comb begin
      lane_sel = '0;
      for (int k = GSIZE - 1; k >= 0; k--) begin
         if (lane_avail[k]) begin
            lane_sel = LANE_W'(k);
         end
      end
   end

   assign pick_word = WADDR_W'({grp_sel, lane_sel});

   always_ff @(posedge clock) begin
      if (cmd.pick) begin
         found_word_ff <= grp_found;
      end
   end

   // free request addressing
   assign pf_ext    = LIM_W'(pf_ff);
   assign free_word = WADDR_W'(pf_ext / WORD_BITS);
   assign free_bit  = BIT_W'(pf_ext % WORD_BITS);

   assign rd_addr = cmd.free_rd ? free_word : pick_word;

   always_ff @(posedge clock) begin
      mem_rd_ff   <= mem[rd_addr];
      rd_valid_ff <= word_valid_ff[rd_addr];
      addr_ff     <= rd_addr;
   end

   // a word never written reads as all free
   assign eff_word = rd_valid_ff ? mem_rd_ff : '0;

   always_comb begin
      zero_found = 1'b0;
      bit_sel    = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (!eff_word[b]) begin
            zero_found = 1'b1;
            bit_sel    = BIT_W'(b);
         end
      end
   end

   assign frame_idx = LIM_W'(addr_ff) * LIM_W'(WORD_BITS) + LIM_W'(bit_sel);
   assign alloc_ok  = found_word_ff && zero_found && (frame_idx < limit);
   assign word_set  = eff_word | (WORD_BITS'(1) << bit_sel);
   assign word_clr  = eff_word & ~(WORD_BITS'(1) << free_bit);

   always_ff @(posedge clock) begin
      if (cmd.find && alloc_ok) begin
         mem[addr_ff] <= word_set;
      end else if (cmd.free_wr) begin
         mem[addr_ff] <= word_clr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_valid_ff <= '0;
         word_full_ff  <= '0;
      end else if (cmd.find && alloc_ok) begin
         word_valid_ff[addr_ff] <= 1'b1;
         word_full_ff[addr_ff]  <= &word_set;
      end else if (cmd.free_wr) begin
         word_valid_ff[addr_ff] <= 1'b1;
         word_full_ff[addr_ff]  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.find || cmd.free_wr || cmd.reply;
      end
   end

   always_comb begin
      rsp_frame_in   = '0;
      rsp_present_in = 1'b0;
      rsp_rw_in      = 1'b0;
      rsp_user_in    = 1'b0;
      rsp_status_in  = bfa_pkg::ST_FREED;
      if (cmd.find) begin
         if (alloc_ok) begin
            rsp_frame_in   = frame_idx[bfa_pkg::PAGE_FRAME_W-1:0];
            rsp_present_in = 1'b1;
            rsp_rw_in      = wr_ff;
            rsp_user_in    = !kern_ff;
            rsp_status_in  = bfa_pkg::ST_ALLOCATED;
         end else begin
            rsp_status_in  = bfa_pkg::ST_NO_FRAME;
         end
      end else if (cmd.reply) begin
         if (action_ff == bfa_pkg::ACT_ALLOC) begin
            rsp_frame_in  = pf_ff;
            rsp_status_in = bfa_pkg::ST_HAD_FRAME;
         end else if (pf_ff == '0) begin
            rsp_status_in = bfa_pkg::ST_NOTHING;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.find || cmd.free_wr || cmd.reply) begin
         rsp_frame_ff   <= rsp_frame_in;
         rsp_present_ff <= rsp_present_in;
         rsp_rw_ff      <= rsp_rw_in;
         rsp_user_ff    <= rsp_user_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_new_frame   = rsp_frame_ff;
   assign rsp_present_bit = rsp_present_ff;
   assign rsp_rw_bit      = rsp_rw_ff;
   assign rsp_user_bit    = rsp_user_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

[src/bitmap_frame_allocator.sv]
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit physical frame allocator over a used-frame bitmap.
// ----------------------------------------------------------------------------
// Usage:
//   Request: drive req_* and raise start; the item is taken on a rising edge
//   with start high and busy low. req_action 0 allocates a frame for an empty
//   page entry, 1 frees the entry's frame.
//   Result: rsp_valid strobes for one cycle with rsp_* valid; the receiver
//   takes it in that cycle and cannot stall it.
//   Sequence: an allocation with a search steps through S_SCAN, S_PICK and
//   S_FIND, a free of a frame through S_FREE_RD and S_FREE_WR, and entries
//   needing no bitmap work through S_REPLY; the strobe is registered from the
//   last state. busy stays high until the last edge of that work, so the next
//   request can be taken while the strobe is high. The search is a registered
//   two-level scan of per-word full flags, one bitmap word read, a bit encode.
//   Configuration: csr_wr_en with csr_wr_data sets the managed frame count;
//   write it only while busy is low.
//   Reset: clears the bitmap (every frame free) through per-word valid flags,
//   no clearing pass; the frame count returns to 4096.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
   parameter int MAX_FRAMES = 4096,
   parameter int WORD_BITS  = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_action,
   input  logic [bfa_pkg::PAGE_FRAME_W-1:0] req_page_frame,
   input  logic                             req_kernel_page,
   input  logic                             req_writable,
   input  logic                             csr_wr_en,
   input  logic [bfa_pkg::CFG_W-1:0]        csr_wr_data,
   output logic                             rsp_valid,
   output logic [bfa_pkg::PAGE_FRAME_W-1:0] rsp_new_frame,
   output logic                             rsp_present_bit,
   output logic                             rsp_rw_bit,
   output logic                             rsp_user_bit,
   output logic [bfa_pkg::STATUS_W-1:0]     rsp_status
);

   bfa_pkg::ctrl_cmd_type  cmd;
   bfa_pkg::ctrl_stat_type stat;

   bfa_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bfa_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .WORD_BITS  (WORD_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_action       (req_action),
      .req_page_frame   (req_page_frame),
      .req_kernel_page  (req_kernel_page),
      .req_writable     (req_writable),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_new_frame    (rsp_new_frame),
      .rsp_present_bit  (rsp_present_bit),
      .rsp_rw_bit       (rsp_rw_bit),
      .rsp_user_bit     (rsp_user_bit),
      .rsp_status       (rsp_status)
   );

endmodule

[src/bfa_checker.sv]
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks of the frame allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bfa_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             start,
   input logic                             busy,
   input logic                             rsp_valid,
   input logic [bfa_pkg::PAGE_FRAME_W-1:0] rsp_new_frame,
   input logic                             rsp_present_bit,
   input logic                             rsp_rw_bit,
   input logic                             rsp_user_bit,
   input logic [bfa_pkg::STATUS_W-1:0]     rsp_status
);

   // an accepted item keeps the block busy for at least the next cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   // the result strobe is never high back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status <= bfa_pkg::ST_NOTHING))
      else $error("result status code out of range");

   // page bits only on a successful allocation
   a_bits_alloc_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bfa_pkg::ST_ALLOCATED)
         |-> !rsp_present_bit && !rsp_rw_bit && !rsp_user_bit)
      else $error("page bits set on a result that is not an allocation");

   a_zero_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == bfa_pkg::ST_NO_FRAME) ||
                    (rsp_status == bfa_pkg::ST_FREED) ||
                    (rsp_status == bfa_pkg::ST_NOTHING))
         |-> (rsp_new_frame == '0))
      else $error("nonzero frame on a failed allocation or free");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_new_frame   (rsp_new_frame),
   .rsp_present_bit (rsp_present_bit),
   .rsp_rw_bit      (rsp_rw_bit),
   .rsp_user_bit    (rsp_user_bit),
   .rsp_status      (rsp_status)
);
